// File: src/pvqm_pkg.sv
// Package for the phase voltage quality monitor.
// Holds widths, register reset values and indexes, payload structs and FSM types.
// No dependencies; every other file of the block imports it.
package pvqm_pkg;

  // Sample format and default record length
  localparam int unsigned SampleBits    = 16;
  localparam int unsigned MaxSamplesDef = 1024;

  // Accumulator and result widths
  localparam int unsigned SumsqW = 41;                 // saturating sum of squares
  localparam int unsigned SumW   = 27;                 // saturating signed sum
  localparam int unsigned MeanW  = SumW + 1;           // signed quotient of the sum
  localparam int unsigned RmsW   = (SumsqW + 1) / 2;   // floor root of a SumsqW word
  localparam int unsigned SqW    = 2 * SampleBits - 1; // square of a sample magnitude

  // Configuration port
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CfgRmsLow  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRmsHigh = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgClip    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgP2pLow  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgP2pHigh = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDc      = 3'd5;

  // Register reset values
  localparam logic [14:0]        RmsLowRst  = 15'd13248;
  localparam logic [14:0]        RmsHighRst = 15'd16192;
  localparam logic [14:0]        ClipRst    = 15'd20794;
  localparam logic [15:0]        P2pLowRst  = 16'd41568;
  localparam logic [15:0]        P2pHighRst = 16'd41600;
  localparam logic signed [15:0] DcRst      = 16'sd1;

  // Status bit positions
  localparam int unsigned StRms  = 0;
  localparam int unsigned StP2p  = 1;
  localparam int unsigned StDc   = 2;
  localparam int unsigned StClip = 3;

  // Input transaction
  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic [1:0]                   phase_tag;
    logic                         last;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [15:0]        rms_value;
    logic [15:0]        peak_to_peak;
    logic signed [15:0] mean_value;
    logic [3:0]         status;
    logic [10:0]        clip_count;
    logic [1:0]         phase_out;
  } out_item_t;

  // Status of the divide / root engine toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } ds_status_t;

  // Top-level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_START,
    ST_CALC,
    ST_LOAD
  } top_state_e;

  // Divide / root engine
  typedef enum logic [2:0] {
    DS_IDLE,
    DS_DIV_MEAN,
    DS_DIV_MS,
    DS_SQRT,
    DS_DONE
  } ds_state_e;

endpackage

// File: src/pvqm_divsqrt.sv
// Divide and square-root engine of the phase voltage quality monitor.
// One shared compare-subtract unit runs two restoring divisions and a digit root.
// Depends on pvqm_pkg.
module pvqm_divsqrt import pvqm_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [SumsqW-1:0]       sumsq_i,
  input  logic signed [SumW-1:0]  sum_i,
  input  logic [CntW-1:0]         count_i,
  output ds_status_t              status_o,
  output logic [RmsW-1:0]         rms_o,
  output logic signed [MeanW-1:0] mean_o
);

  localparam int unsigned UnitW     = SumsqW + 1;
  localparam int unsigned DivSteps  = SumsqW;
  localparam int unsigned SqrtSteps = RmsW;
  localparam int unsigned StepW     = $clog2(DivSteps);
  localparam logic [SumsqW-1:0] BitInit = SumsqW'(1) << (2 * (SqrtSteps - 1));

  ds_state_e state_q, state_d;

  logic [UnitW-1:0]        rem_q;
  logic [SumsqW-1:0]       quo_q;
  logic [CntW-1:0]         div_q;
  logic                    neg_q;
  logic [SumsqW-1:0]       root_q;
  logic [SumsqW-1:0]       bit_q;
  logic [StepW-1:0]        step_q;
  logic [RmsW-1:0]         rms_q;
  logic signed [MeanW-1:0] mean_q;

  // Shared unit and control
  logic              unit_sqrt;
  logic              last_step;
  logic [UnitW-1:0]  unit_a, unit_b;
  logic [UnitW:0]    unit_diff;
  logic              unit_ge;
  logic [UnitW-1:0]  rem_next;
  logic [SumsqW-1:0] quo_next;
  logic [SumsqW-1:0] root_next;
  logic [SumW-1:0]   sum_mag;
  logic signed [MeanW-1:0] mean_mag;

  // Magnitude of the sum; the sign is applied to the quotient
  assign sum_mag  = sum_i[SumW-1] ? SumW'(-sum_i) : SumW'(sum_i);
  assign mean_mag = MeanW'(quo_next);

  // Compare-subtract: a division step or a root step
  always_comb begin
    if (unit_sqrt) begin
      unit_a = rem_q;
      unit_b = UnitW'(root_q | bit_q);
    end else begin
      unit_a = {rem_q[UnitW-2:0], quo_q[SumsqW-1]};
      unit_b = UnitW'(div_q);
    end
    unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    unit_ge   = ~unit_diff[UnitW];
    rem_next  = unit_ge ? unit_diff[UnitW-1:0] : unit_a;
    quo_next  = {quo_q[SumsqW-2:0], unit_ge};
    root_next = unit_ge ? ((root_q >> 1) | bit_q) : (root_q >> 1);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      DS_IDLE, DS_DONE: begin
        if (start_i) state_d = DS_DIV_MEAN;
      end
      DS_DIV_MEAN: begin
        if (last_step) state_d = DS_DIV_MS;
      end
      DS_DIV_MS: begin
        if (last_step) state_d = DS_SQRT;
      end
      DS_SQRT: begin
        if (last_step) state_d = DS_DONE;
      end
      default: state_d = DS_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    unit_sqrt     = (state_q == DS_SQRT);
    last_step     = unit_sqrt ? (step_q == StepW'(SqrtSteps - 1))
                              : (step_q == StepW'(DivSteps - 1));
    status_o.busy = (state_q == DS_DIV_MEAN) || (state_q == DS_DIV_MS) ||
                    (state_q == DS_SQRT);
    status_o.done = (state_q == DS_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath; sumsq_i is held by the caller until the result is taken
  always_ff @(posedge clk_i) begin
    case (state_q)
      DS_IDLE, DS_DONE: begin
        if (start_i) begin
          rem_q  <= '0;
          quo_q  <= SumsqW'(sum_mag);
          div_q  <= (count_i == '0) ? CntW'(1) : count_i;
          neg_q  <= sum_i[SumW-1];
          step_q <= '0;
        end
      end
      DS_DIV_MEAN: begin
        rem_q  <= rem_next;
        quo_q  <= quo_next;
        step_q <= step_q + StepW'(1);
        if (last_step) begin
          mean_q <= neg_q ? -mean_mag : mean_mag;
          rem_q  <= '0;
          quo_q  <= sumsq_i;
          step_q <= '0;
        end
      end
      DS_DIV_MS: begin
        rem_q  <= rem_next;
        quo_q  <= quo_next;
        step_q <= step_q + StepW'(1);
        if (last_step) begin
          rem_q  <= UnitW'(quo_next);
          root_q <= '0;
          bit_q  <= BitInit;
          step_q <= '0;
        end
      end
      DS_SQRT: begin
        rem_q  <= rem_next;
        root_q <= root_next;
        bit_q  <= bit_q >> 2;
        step_q <= step_q + StepW'(1);
        if (last_step) rms_q <= root_next[RmsW-1:0];
      end
      default: begin
        step_q <= '0;
      end
    endcase
  end

  assign rms_o  = rms_q;
  assign mean_o = mean_q;

endmodule

// File: src/phase_voltage_quality_monitor_top.sv
// Top level of the phase voltage quality monitor: ports, registers, accumulators.
// Depends on pvqm_pkg and pvqm_divsqrt.
//
// Each sample transaction is accepted, its magnitude is squared in the one
// multiplier, then it is added into the saturating accumulators; stall is
// high meanwhile. A transaction with last set then starts the divide / root
// engine, whose single compare-subtract unit runs 41 steps for the mean, 41
// for the mean square and 21 for the root; the result is then loaded once
// the output register is free. The result waits in an output register; the
// next record's samples are taken while it waits, and a following record
// closes only once that register is free. A record holds at most MAX_SAMPLES
// samples; later ones are dropped until last closes it.
module phase_voltage_quality_monitor_top import pvqm_pkg::*; #(
  parameter int unsigned MAX_SAMPLES = MaxSamplesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_SAMPLES);

  top_state_e state_q, state_d;

  // Configuration registers
  logic [14:0]        rms_low_q, rms_high_q, clip_lvl_q;
  logic [15:0]        p2p_low_q, p2p_high_q;
  logic signed [15:0] dc_limit_q;

  // Captured transaction and record accumulators
  logic signed [SampleBits-1:0] sample_q;
  logic [1:0]                   tag_q;
  logic                         last_q;
  logic                         acc_en_q;
  logic [SqW-1:0]               sq_q;
  logic [SumsqW-1:0]            sumsq_q;
  logic signed [SumW-1:0]       sum_q;
  logic signed [SampleBits-1:0] max_q, min_q;
  logic [CntW-1:0]              cnt_q, clip_q;

  logic      out_valid_q;
  out_item_t out_data_q;

  // Sequencer outputs
  logic capture, ds_start, out_free, load;

  // Engine interface
  ds_status_t              ds_status;
  logic [RmsW-1:0]         ds_rms;
  logic signed [MeanW-1:0] ds_mean;

  // Per-sample arithmetic
  logic signed [SampleBits:0]   smp_ext;
  logic [SampleBits:0]          mag;
  logic [2*SampleBits+1:0]      prod;
  logic signed [SumW:0]         sum_ext;
  logic signed [SumW-1:0]       sum_sat;
  logic [SumsqW:0]              sumsq_ext;
  logic                         clip_hit;

  // Result arithmetic
  logic signed [SampleBits:0]   p2p_s;
  logic [SampleBits:0]          p2p_u;
  logic [3:0]                   status;

  assign smp_ext  = (SampleBits + 1)'(sample_q);
  assign mag      = smp_ext[SampleBits] ? (SampleBits + 1)'(-smp_ext)
                                        : (SampleBits + 1)'(smp_ext);
  assign prod     = mag * mag;
  assign clip_hit = (mag >= (SampleBits + 1)'(clip_lvl_q));

  // Saturate the signed sum on overflow of either sign
  always_comb begin
    sum_ext = (SumW + 1)'(sum_q) + (SumW + 1)'(sample_q);
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      sum_sat = sum_ext[SumW] ? {1'b1, {(SumW - 1){1'b0}}} : {1'b0, {(SumW - 1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SumW-1:0];
    end
  end

  assign sumsq_ext = {1'b0, sumsq_q} + (SumsqW + 1)'(sq_q);

  // Status flags from the engine results and the accumulators
  always_comb begin
    p2p_s          = (SampleBits + 1)'(max_q) - (SampleBits + 1)'(min_q);
    p2p_u          = p2p_s;
    status         = '0;
    status[StRms]  = (ds_rms <= RmsW'(rms_low_q)) || (ds_rms >= RmsW'(rms_high_q));
    status[StP2p]  = (p2p_u < (SampleBits + 1)'(p2p_low_q)) ||
                     (p2p_u > (SampleBits + 1)'(p2p_high_q));
    status[StDc]   = (ds_mean >= MeanW'(dc_limit_q));
    status[StClip] = (clip_q != '0);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ACCUM;
      ST_ACCUM:  state_d = last_q ? ST_START : ST_IDLE;
      ST_START:  state_d = ST_CALC;
      ST_CALC:   if (ds_status.done) state_d = ST_LOAD;
      ST_LOAD:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    capture    = (state_q == ST_IDLE) && in_valid_i;
    ds_start   = (state_q == ST_START);
    out_free   = !out_valid_q || !out_stall_i;
    load       = (state_q == ST_LOAD) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Write configuration registers; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rms_low_q  <= RmsLowRst;
      rms_high_q <= RmsHighRst;
      clip_lvl_q <= ClipRst;
      p2p_low_q  <= P2pLowRst;
      p2p_high_q <= P2pHighRst;
      dc_limit_q <= DcRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRmsLow:  rms_low_q  <= cfg_wdata_i[14:0];
        CfgRmsHigh: rms_high_q <= cfg_wdata_i[14:0];
        CfgClip:    clip_lvl_q <= cfg_wdata_i[14:0];
        CfgP2pLow:  p2p_low_q  <= cfg_wdata_i;
        CfgP2pHigh: p2p_high_q <= cfg_wdata_i;
        CfgDc:      dc_limit_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // Capture the sample transaction and square its magnitude
  always_ff @(posedge clk_i) begin
    if (capture) begin
      sample_q <= in_data_i.sample;
      tag_q    <= in_data_i.phase_tag;
      last_q   <= in_data_i.last;
    end
    if (state_q == ST_SQUARE) begin
      sq_q     <= prod[SqW-1:0];
      acc_en_q <= (cnt_q < MaxCnt);
    end
  end

  // Record accumulators; clear when the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sumsq_q <= '0;
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= '0;
      cnt_q   <= '0;
      clip_q  <= '0;
    end else if (load) begin
      sumsq_q <= '0;
      sum_q   <= '0;
      max_q   <= '0;
      min_q   <= '0;
      cnt_q   <= '0;
      clip_q  <= '0;
    end else if ((state_q == ST_SQUARE) && (cnt_q < MaxCnt)) begin
      sum_q <= sum_sat;
      if (cnt_q == '0) begin
        max_q <= sample_q;
        min_q <= sample_q;
      end else begin
        if (sample_q > max_q) max_q <= sample_q;
        if (sample_q < min_q) min_q <= sample_q;
      end
      if (clip_hit) clip_q <= clip_q + CntW'(1);
      cnt_q <= cnt_q + CntW'(1);
    end else if ((state_q == ST_ACCUM) && acc_en_q) begin
      sumsq_q <= sumsq_ext[SumsqW] ? {SumsqW{1'b1}} : sumsq_ext[SumsqW-1:0];
    end
  end

  // Mean, mean square and root
  pvqm_divsqrt #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_divsqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ds_start),
    .sumsq_i  (sumsq_q),
    .sum_i    (sum_q),
    .count_i  (cnt_q),
    .status_o (ds_status),
    .rms_o    (ds_rms),
    .mean_o   (ds_mean)
  );

  // Hold the result transaction until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.rms_value    <= 16'(ds_rms);
      out_data_q.peak_to_peak <= p2p_u[15:0];
      out_data_q.mean_value   <= ds_mean[15:0];
      out_data_q.status       <= status;
      out_data_q.clip_count   <= 11'(clip_q);
      out_data_q.phase_out    <= tag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // An accepted sample always goes on to the squaring step
  a_accept_squares: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SQUARE))
    else $error("accepted sample did not reach the squaring step");

  // The engine only runs while the sequencer waits for it
  a_engine_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ds_status.busy |-> (state_q == ST_CALC))
    else $error("engine busy outside the calculation wait");

  // Loading a result clears the record and presents the result
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (cnt_q == '0) && (sumsq_q == '0) && out_valid_q)
    else $error("record not cleared or result not presented after load");

  // The sample count never passes the record limit
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("sample count exceeds the record limit");
`endif

endmodule
